[src/delimited_frame_sum_checker_macros.svh]
// ----------------------------------------------------------------------------
// delimited_frame_sum_checker_macros.svh
// Assertion helpers used by the checker file dfsc_checker.sv.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_FRAME_SUM_CHECKER_MACROS_SVH
`define DELIMITED_FRAME_SUM_CHECKER_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define DFSC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define DFSC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/dfsc_pkg.sv]
// ----------------------------------------------------------------------------
// dfsc_pkg
// Frame geometry, delimiter codes and shared types of the frame checker.
// ----------------------------------------------------------------------------
package dfsc_pkg;

   localparam int PAYLOAD_BYTES = 4;
   localparam int FRAME_BYTES   = PAYLOAD_BYTES + 4;
   localparam int COUNT_W       = $clog2(FRAME_BYTES + 1);
   localparam int INDEX_W       = $clog2(FRAME_BYTES);
   localparam int REMAIN_W      = $clog2(PAYLOAD_BYTES + 1);

   typedef logic [7:0]          byte_type;
   typedef logic [15:0]         sum_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [REMAIN_W-1:0] remain_type;

   localparam byte_type START_MARK = 8'h2A;  // '*'
   localparam byte_type END_MARK   = 8'h23;  // '#'

endpackage

[src/dfsc_if.sv]
// ----------------------------------------------------------------------------
// dfsc_if
// Valid/ready channels: received bytes in, payload bytes out.
// ----------------------------------------------------------------------------
interface dfsc_req_if import dfsc_pkg::*;;
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfsc_rsp_if import dfsc_pkg::*;;
   logic     valid;
   logic     ready;
   byte_type payload_byte;
   logic     payload_last;

   modport source (output valid, output payload_byte, output payload_last, input ready);
   modport sink   (input valid, input payload_byte, input payload_last, output ready);
endinterface

[src/delimited_frame_sum_checker.sv]
// ----------------------------------------------------------------------------
// delimited_frame_sum_checker
// A validated frame's first payload item shows in the cycle after '#' is taken.
// Throughput: one received byte per cycle while not stalled; a frame drains one
// item per cycle while rsp ready is high. Input stalls only while a frame is
// still draining and the window is nearly full (set by the single payload
// buffer). Synchronous active-high reset empties the window and payload buffer.
// ----------------------------------------------------------------------------
module delimited_frame_sum_checker import dfsc_pkg::*; (
   input logic         clock,
   input logic         reset,
   dfsc_req_if.sink    req_chan,
   dfsc_rsp_if.source  rsp_chan
);

   byte_type   window_ff [FRAME_BYTES];
   byte_type   window_in [FRAME_BYTES];
   count_type  fill_ff;
   count_type  fill_in;

   byte_type   payload_ff [PAYLOAD_BYTES];
   remain_type remain_ff;

   sum_type    local_sum;
   sum_type    remote_sum;
   logic       frame_hit;
   logic       req_fire;
   logic       rsp_fire;
   logic       rsp_busy;

   assign rsp_busy = (remain_ff != '0);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // a frame can only complete once the window is at least one short of full
   assign req_chan.ready = !(rsp_busy && (fill_ff >= count_type'(FRAME_BYTES - 1)));

   always_comb begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
         window_in[i] = window_ff[i];
      end
      fill_in = fill_ff;
      if (fill_ff == count_type'(FRAME_BYTES)) begin
         for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            window_in[i] = window_ff[i + 1];
         end
         window_in[FRAME_BYTES - 1] = req_chan.rx_byte;
      end else begin
         window_in[fill_ff[INDEX_W-1:0]] = req_chan.rx_byte;
         fill_in = fill_ff + count_type'(1);
      end
   end

   always_comb begin
      local_sum = '0;
      for (int k = 0; k < PAYLOAD_BYTES; k++) begin
         local_sum = local_sum + sum_type'(window_in[1 + k]);
      end
      remote_sum = {window_in[PAYLOAD_BYTES + 1], window_in[PAYLOAD_BYTES + 2]};
      frame_hit  = (fill_in == count_type'(FRAME_BYTES))
                && (window_in[FRAME_BYTES - 1] == END_MARK)
                && (window_in[0] == START_MARK)
                && (local_sum == remote_sum);
   end

   // window contents need no reset: entries are written before fill reaches them
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int i = 0; i < FRAME_BYTES; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (req_fire) begin
         fill_ff <= frame_hit ? count_type'(0) : fill_in;
      end
   end

   // payload buffer shifts toward entry 0 as items leave
   always_ff @(posedge clock) begin
      if (req_fire && frame_hit) begin
         for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            payload_ff[k] <= window_in[1 + k];
         end
      end else if (rsp_fire) begin
         for (int k = 0; k < PAYLOAD_BYTES - 1; k++) begin
            payload_ff[k] <= payload_ff[k + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else if (req_fire && frame_hit) begin
         remain_ff <= remain_type'(PAYLOAD_BYTES);
      end else if (rsp_fire) begin
         remain_ff <= remain_ff - remain_type'(1);
      end
   end

   assign rsp_chan.valid        = rsp_busy;
   assign rsp_chan.payload_byte = payload_ff[0];
   assign rsp_chan.payload_last = (remain_ff == remain_type'(1));

endmodule

[src/dfsc_checker.sv]
// ----------------------------------------------------------------------------
// dfsc_checker
// Port-level checks of the frame checker's result stream.
// ----------------------------------------------------------------------------
`include "delimited_frame_sum_checker_macros.svh"

module dfsc_checker import dfsc_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input byte_type payload_byte,
   input logic     payload_last
);

   `DFSC_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> !rsp_valid, "result valid right after reset")

   `DFSC_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(payload_byte) && $stable(payload_last)), "stalled result changed")

   `DFSC_ASSERT(a_frame_continues, clock, reset, (rsp_valid && rsp_ready && !payload_last) |=> rsp_valid, "frame ended before its last item")

   `DFSC_ASSERT(a_gap_after_last, clock, reset, (rsp_valid && rsp_ready && payload_last) |=> !rsp_valid, "new frame right after last item")

endmodule

bind delimited_frame_sum_checker dfsc_checker u_dfsc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .payload_byte (rsp_chan.payload_byte),
   .payload_last (rsp_chan.payload_last)
);
